>>> hw/rtl/cpt_pkg.sv
// Shared types and constants for the closest point on triangle block.
package cpt_pkg;

  localparam int COORD_W = 32;              // Q16.16 coordinate
  localparam int DIFF_W  = COORD_W + 1;     // difference of two coordinates
  localparam int QDEPTH  = 4;               // words held between front and back
  localparam int QPTR_W  = $clog2(QDEPTH);

  typedef logic [2:0][COORD_W-1:0] coord3_t;
  typedef logic [2:0][DIFF_W-1:0]  diff3_t;

  // Raw input word: three vertices and the query point
  typedef struct packed {
    coord3_t a;
    coord3_t b;
    coord3_t c;
    coord3_t q;
  } tri_pt_t;

  // Queued word: raw points plus edge vectors from vertex A
  typedef struct packed {
    tri_pt_t pt;
    diff3_t  ab;
    diff3_t  ac;
    diff3_t  aq;
  } item_t;

  typedef enum logic [1:0] {
    REG_INSIDE = 2'd0,
    REG_AC     = 2'd1,
    REG_AB     = 2'd2,
    REG_BC     = 2'd3
  } region_t;

endpackage

>>> hw/rtl/cpt_front.sv
// Front end: takes input words, forms the edge vectors, hands words to the queue.
module cpt_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  cpt_pkg::tri_pt_t in_pt,
  input  logic             q_full,
  output logic             q_push,
  output cpt_pkg::item_t   q_item
);
  import cpt_pkg::*;

  logic  stg_vld_r, stg_vld_nxt;
  item_t stg_r, stg_nxt;
  logic  accept;

  assign busy   = stg_vld_r & q_full;
  assign accept = start & ~busy;
  assign q_push = stg_vld_r & ~q_full;
  assign q_item = stg_r;

  // Edge vectors AB, AC, AQ at one extra bit
  always_comb begin
    stg_nxt    = stg_r;
    stg_nxt.pt = in_pt;
    for (int i = 0; i < 3; i++) begin
      stg_nxt.ab[i] = DIFF_W'($signed(in_pt.b[i])) - DIFF_W'($signed(in_pt.a[i]));
      stg_nxt.ac[i] = DIFF_W'($signed(in_pt.c[i])) - DIFF_W'($signed(in_pt.a[i]));
      stg_nxt.aq[i] = DIFF_W'($signed(in_pt.q[i])) - DIFF_W'($signed(in_pt.a[i]));
    end
  end

  assign stg_vld_nxt = accept | (stg_vld_r & q_full);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
    end else begin
      stg_vld_r <= stg_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stg_r <= stg_nxt;
    end
  end

endmodule

>>> hw/rtl/cpt_queue.sv
// Short FIFO of words between the front end and the back end.
module cpt_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  cpt_pkg::item_t wr_item,
  output logic           full,
  input  logic           pop,
  output logic           vld,
  output cpt_pkg::item_t rd_item
);
  import cpt_pkg::*;

  item_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;

  assign full    = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign vld     = (cnt_r != '0);
  assign rd_item = mem_r[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

>>> hw/rtl/cpt_back.sv
// Back end: sequenced exact arithmetic on a shared multiplier and divider.
module cpt_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_vld,
  input  cpt_pkg::item_t   q_item,
  output logic             q_pop,
  output logic             out_valid,
  output cpt_pkg::coord3_t near,
  output cpt_pkg::region_t region,
  output logic             degenerate
);
  import cpt_pkg::*;

  localparam int DOT_W     = 68;            // dot products of edge vectors
  localparam int CRS_W     = 138;           // denominator and numerators
  localparam int OPA_W     = 140;           // multiplier wide operand
  localparam int OPB_W     = 72;            // multiplier narrow operand
  localparam int ACC_W     = 176;           // product accumulator
  localparam int QUO_W     = 35;            // quotient bits
  localparam int MAC_STEPS = OPB_W / 8;
  localparam int NSRC      = 17;

  localparam logic [4:0] K_SETUP_LAST  = 5'd20;
  localparam logic [4:0] K_INSIDE_LAST = 5'd2;
  localparam logic [4:0] K_EDOT_LAST   = 5'd5;

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_LOAD  = 9'b000000010,
    ST_MAC   = 9'b000000100,
    ST_ACC   = 9'b000001000,
    ST_CLASS = 9'b000010000,
    ST_CLAMP = 9'b000100000,
    ST_DSET  = 9'b001000000,
    ST_DIV   = 9'b010000000,
    ST_RND   = 9'b100000000
  } state_t;

  typedef enum logic [3:0] {
    PH_SETUP  = 4'b0001,
    PH_INSIDE = 4'b0010,
    PH_EDOT   = 4'b0100,
    PH_EAXIS  = 4'b1000
  } phase_t;

  typedef enum logic [4:0] {
    SRC_AB, SRC_AC, SRC_AQ, SRC_A, SRC_B, SRC_C, SRC_E, SRC_SQ,
    SRC_D00, SRC_D01, SRC_D11, SRC_D20, SRC_D21, SRC_UN, SRC_VN, SRC_WN, SRC_TN
  } src_t;

  typedef enum logic [3:0] {
    DST_NONE, DST_D00, DST_D01, DST_D11, DST_D20, DST_D21,
    DST_DEN, DST_VN, DST_WN, DST_TN, DST_EE
  } dst_t;

  typedef struct packed {
    src_t       sa;
    src_t       sb;
    logic [1:0] ax;
    logic       first;
    logic       neg;
    logic       last;
    dst_t       dst;
  } uop_t;

  state_t state_r, state_nxt;
  phase_t ph_r, ph_nxt;
  logic [4:0] k_r, k_nxt;
  logic [1:0] axis_r, axis_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic       out_vld_r, out_vld_nxt;

  item_t cur_r, cur_nxt;
  logic [OPA_W-1:0] ma_r, ma_nxt;
  logic [OPB_W-1:0] mb_r, mb_nxt;
  logic             psign_r, psign_nxt;
  logic [ACC_W-1:0] prod_r, prod_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic signed [DOT_W-1:0] d00_r, d01_r, d11_r, d20_r, d21_r, tn_r, ee_r;
  logic signed [DOT_W-1:0] d00_nxt, d01_nxt, d11_nxt, d20_nxt, d21_nxt, tn_nxt, ee_nxt;
  logic signed [CRS_W-1:0] den_r, vn_r, wn_r, den_nxt, vn_nxt, wn_nxt;
  logic signed [OPA_W-1:0] un_r, un_nxt;
  logic [ACC_W-1:0] rem_r, rem_nxt, dsh_r, dsh_nxt;
  logic [CRS_W-1:0] dvs_r, dvs_nxt;
  logic [QUO_W-1:0] quo_r, quo_nxt;
  logic             nneg_r, nneg_nxt;
  coord3_t          res_r, res_nxt;
  region_t          region_r, region_nxt;
  logic             degen_r, degen_nxt;

  uop_t       op;
  logic [2:0] grp;
  logic [4:0] gbase;
  logic signed [OPA_W-1:0] srcv [NSRC];
  logic signed [OPA_W-1:0] opa;
  logic signed [OPB_W-1:0] opb;
  logic signed [DIFF_W-1:0]  e3 [3];
  logic signed [DIFF_W-1:0]  sq3 [3];
  logic signed [COORD_W-1:0] s3 [3];
  logic signed [COORD_W-1:0] t3 [3];

  logic [OPA_W+7:0]        pp;
  logic signed [ACC_W-1:0] psum, accsum;
  logic signed [OPA_W-1:0] un_c;
  logic [ACC_W-1:0]        acc_abs;
  logic [CRS_W-1:0]        dvs_c;
  logic [CRS_W:0]          rem2;
  logic [QUO_W:0]          qr;
  logic signed [QUO_W+1:0] sres, rval;
  logic signed [COORD_W-1:0] rbase;
  logic                    den_pos, tn_le0, tn_ge;

  assign q_pop      = (state_r == ST_IDLE) & q_vld;
  assign out_valid  = out_vld_r;
  assign near       = res_r;
  assign region     = region_r;
  assign degenerate = degen_r;

  // Edge end points for the chosen region, edge vector and query offset
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s3[i]  = (region_r == REG_BC) ? $signed(cur_r.pt.b[i]) : $signed(cur_r.pt.a[i]);
      t3[i]  = (region_r == REG_AB) ? $signed(cur_r.pt.b[i]) : $signed(cur_r.pt.c[i]);
      e3[i]  = DIFF_W'(t3[i]) - DIFF_W'(s3[i]);
      sq3[i] = DIFF_W'($signed(cur_r.pt.q[i])) - DIFF_W'(s3[i]);
    end
  end

  // Micro-op decode for the current phase and step
  always_comb begin
    op  = '{sa: SRC_AB, sb: SRC_AB, ax: 2'd0, first: 1'b0, neg: 1'b0, last: 1'b0,
            dst: DST_NONE};
    grp = 3'd0;
    priority if (k_r < 5'd3)  grp = 3'd0;
    else if (k_r < 5'd6)      grp = 3'd1;
    else if (k_r < 5'd9)      grp = 3'd2;
    else if (k_r < 5'd12)     grp = 3'd3;
    else                      grp = 3'd4;
    gbase = 5'(grp) * 5'd3;
    unique case (ph_r)
      PH_SETUP: begin
        if (k_r < 5'd15) begin
          op.ax    = 2'(k_r - gbase);
          op.first = (op.ax == 2'd0);
          op.last  = (op.ax == 2'd2);
          unique case (grp)
            3'd0:    begin op.sa = SRC_AB; op.sb = SRC_AB; op.dst = DST_D00; end
            3'd1:    begin op.sa = SRC_AB; op.sb = SRC_AC; op.dst = DST_D01; end
            3'd2:    begin op.sa = SRC_AC; op.sb = SRC_AC; op.dst = DST_D11; end
            3'd3:    begin op.sa = SRC_AQ; op.sb = SRC_AB; op.dst = DST_D20; end
            3'd4:    begin op.sa = SRC_AQ; op.sb = SRC_AC; op.dst = DST_D21; end
            default: begin op.dst = DST_NONE; end
          endcase
        end else begin
          // Cross terms: den, vnum, wnum as differences of two products
          op.first = k_r[0];
          op.neg   = ~k_r[0];
          op.last  = ~k_r[0];
          unique case (k_r)
            5'd15:   begin op.sa = SRC_D00; op.sb = SRC_D11; end
            5'd16:   begin op.sa = SRC_D01; op.sb = SRC_D01; op.dst = DST_DEN; end
            5'd17:   begin op.sa = SRC_D11; op.sb = SRC_D20; end
            5'd18:   begin op.sa = SRC_D01; op.sb = SRC_D21; op.dst = DST_VN; end
            5'd19:   begin op.sa = SRC_D00; op.sb = SRC_D21; end
            5'd20:   begin op.sa = SRC_D01; op.sb = SRC_D20; op.dst = DST_WN; end
            default: begin op.dst = DST_NONE; end
          endcase
        end
      end
      PH_INSIDE: begin
        op.ax    = axis_r;
        op.first = (k_r == 5'd0);
        op.last  = (k_r == K_INSIDE_LAST);
        unique case (k_r)
          5'd0:    begin op.sa = SRC_UN; op.sb = SRC_A; end
          5'd1:    begin op.sa = SRC_VN; op.sb = SRC_B; end
          default: begin op.sa = SRC_WN; op.sb = SRC_C; end
        endcase
      end
      PH_EDOT: begin
        if (k_r < 5'd3) begin
          op.ax    = 2'(k_r);
          op.sa    = SRC_SQ;
          op.sb    = SRC_E;
          op.first = (k_r == 5'd0);
          op.last  = (k_r == 5'd2);
          op.dst   = DST_TN;
        end else begin
          op.ax    = 2'(k_r - 5'd3);
          op.sa    = SRC_E;
          op.sb    = SRC_E;
          op.first = (k_r == 5'd3);
          op.last  = (k_r == K_EDOT_LAST);
          op.dst   = DST_EE;
        end
      end
      PH_EAXIS: begin
        op.ax    = axis_r;
        op.sa    = SRC_TN;
        op.sb    = SRC_E;
        op.first = 1'b1;
        op.last  = 1'b1;
      end
      default: begin
        op.dst = DST_NONE;
      end
    endcase
  end

  // Operand sources
  always_comb begin
    srcv[SRC_AB]  = OPA_W'($signed(cur_r.ab[op.ax]));
    srcv[SRC_AC]  = OPA_W'($signed(cur_r.ac[op.ax]));
    srcv[SRC_AQ]  = OPA_W'($signed(cur_r.aq[op.ax]));
    srcv[SRC_A]   = OPA_W'($signed(cur_r.pt.a[op.ax]));
    srcv[SRC_B]   = OPA_W'($signed(cur_r.pt.b[op.ax]));
    srcv[SRC_C]   = OPA_W'($signed(cur_r.pt.c[op.ax]));
    srcv[SRC_E]   = OPA_W'(e3[op.ax]);
    srcv[SRC_SQ]  = OPA_W'(sq3[op.ax]);
    srcv[SRC_D00] = OPA_W'(d00_r);
    srcv[SRC_D01] = OPA_W'(d01_r);
    srcv[SRC_D11] = OPA_W'(d11_r);
    srcv[SRC_D20] = OPA_W'(d20_r);
    srcv[SRC_D21] = OPA_W'(d21_r);
    srcv[SRC_UN]  = un_r;
    srcv[SRC_VN]  = OPA_W'(vn_r);
    srcv[SRC_WN]  = OPA_W'(wn_r);
    srcv[SRC_TN]  = OPA_W'(tn_r);
    opa = srcv[op.sa];
    opb = $signed(srcv[op.sb][OPB_W-1:0]);
  end

  // Shared arithmetic
  always_comb begin
    pp      = ma_r * mb_r[OPB_W-1 -: 8];
    psum    = psign_r ? -$signed(prod_r) : $signed(prod_r);
    accsum  = (op.first ? '0 : acc_r) + psum;
    un_c    = OPA_W'(den_r) - OPA_W'(vn_r) - OPA_W'(wn_r);
    acc_abs = acc_r[ACC_W-1] ? -acc_r : acc_r;
    dvs_c   = ph_r[3] ? CRS_W'(ee_r) : den_r;
    den_pos = ~den_r[CRS_W-1] & (den_r != '0);
    tn_le0  = tn_r[DOT_W-1] | (tn_r == '0);
    tn_ge   = (ee_r == '0) | (tn_r >= ee_r);
    rem2    = {rem_r[CRS_W-1:0], 1'b0};
    qr      = {1'b0, quo_r} + (QUO_W+1)'(rem2 >= {1'b0, dvs_r});
    sres    = nneg_r ? -$signed({1'b0, qr}) : $signed({1'b0, qr});
    rbase   = (ph_r == PH_EAXIS) ? s3[axis_r] : '0;
    rval    = (QUO_W+2)'(rbase) + sres;
  end

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    ph_nxt      = ph_r;
    k_nxt       = k_r;
    axis_nxt    = axis_r;
    cnt_nxt     = cnt_r;
    out_vld_nxt = 1'b0;
    cur_nxt     = cur_r;
    ma_nxt      = ma_r;
    mb_nxt      = mb_r;
    psign_nxt   = psign_r;
    prod_nxt    = prod_r;
    acc_nxt     = acc_r;
    d00_nxt     = d00_r;
    d01_nxt     = d01_r;
    d11_nxt     = d11_r;
    d20_nxt     = d20_r;
    d21_nxt     = d21_r;
    tn_nxt      = tn_r;
    ee_nxt      = ee_r;
    den_nxt     = den_r;
    vn_nxt      = vn_r;
    wn_nxt      = wn_r;
    un_nxt      = un_r;
    rem_nxt     = rem_r;
    dsh_nxt     = dsh_r;
    dvs_nxt     = dvs_r;
    quo_nxt     = quo_r;
    nneg_nxt    = nneg_r;
    res_nxt     = res_r;
    region_nxt  = region_r;
    degen_nxt   = degen_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_vld) begin
          cur_nxt   = q_item;
          ph_nxt    = PH_SETUP;
          k_nxt     = '0;
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        ma_nxt    = opa[OPA_W-1] ? -opa : opa;
        mb_nxt    = opb[OPB_W-1] ? -opb : opb;
        psign_nxt = opa[OPA_W-1] ^ opb[OPB_W-1] ^ op.neg;
        prod_nxt  = '0;
        cnt_nxt   = '0;
        state_nxt = ST_MAC;
      end
      ST_MAC: begin
        // One byte of the narrow operand per cycle, top byte first
        prod_nxt = {prod_r[ACC_W-9:0], 8'd0} + ACC_W'(pp);
        mb_nxt   = {mb_r[OPB_W-9:0], 8'd0};
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == 6'(MAC_STEPS - 1)) begin
          state_nxt = ST_ACC;
        end
      end
      ST_ACC: begin
        acc_nxt = accsum;
        if (op.last) begin
          unique case (op.dst)
            DST_D00: d00_nxt = accsum[DOT_W-1:0];
            DST_D01: d01_nxt = accsum[DOT_W-1:0];
            DST_D11: d11_nxt = accsum[DOT_W-1:0];
            DST_D20: d20_nxt = accsum[DOT_W-1:0];
            DST_D21: d21_nxt = accsum[DOT_W-1:0];
            DST_DEN: den_nxt = accsum[CRS_W-1:0];
            DST_VN:  vn_nxt  = accsum[CRS_W-1:0];
            DST_WN:  wn_nxt  = accsum[CRS_W-1:0];
            DST_TN:  tn_nxt  = accsum[DOT_W-1:0];
            DST_EE:  ee_nxt  = accsum[DOT_W-1:0];
            default: acc_nxt = accsum;
          endcase
        end
        k_nxt     = k_r + 1'b1;
        state_nxt = ST_LOAD;
        unique case (ph_r)
          PH_SETUP:  if (k_r == K_SETUP_LAST)  state_nxt = ST_CLASS;
          PH_INSIDE: if (k_r == K_INSIDE_LAST) state_nxt = ST_DSET;
          PH_EDOT:   if (k_r == K_EDOT_LAST)   state_nxt = ST_CLAMP;
          PH_EAXIS:  state_nxt = ST_DSET;
          default:   state_nxt = ST_IDLE;
        endcase
      end
      ST_CLASS: begin
        un_nxt = un_c;
        k_nxt  = '0;
        if (!den_pos) begin
          // Zero-area triangle: hand back the query point
          res_nxt     = cur_r.pt.q;
          region_nxt  = REG_INSIDE;
          degen_nxt   = 1'b1;
          out_vld_nxt = 1'b1;
          state_nxt   = ST_IDLE;
        end else begin
          degen_nxt = 1'b0;
          state_nxt = ST_LOAD;
          if (!un_c[OPA_W-1] && !vn_r[CRS_W-1] && !wn_r[CRS_W-1]) begin
            region_nxt = REG_INSIDE;
            ph_nxt     = PH_INSIDE;
            axis_nxt   = '0;
          end else begin
            priority if (vn_r[CRS_W-1]) region_nxt = REG_AC;
            else if (wn_r[CRS_W-1])     region_nxt = REG_AB;
            else                        region_nxt = REG_BC;
            ph_nxt = PH_EDOT;
          end
        end
      end
      ST_CLAMP: begin
        // Clamp the edge parameter at either end
        if (tn_le0) begin
          for (int i = 0; i < 3; i++) res_nxt[i] = s3[i];
          out_vld_nxt = 1'b1;
          state_nxt   = ST_IDLE;
        end else if (tn_ge) begin
          for (int i = 0; i < 3; i++) res_nxt[i] = t3[i];
          out_vld_nxt = 1'b1;
          state_nxt   = ST_IDLE;
        end else begin
          ph_nxt    = PH_EAXIS;
          axis_nxt  = '0;
          k_nxt     = '0;
          state_nxt = ST_LOAD;
        end
      end
      ST_DSET: begin
        rem_nxt   = acc_abs;
        nneg_nxt  = acc_r[ACC_W-1];
        dvs_nxt   = dvs_c;
        dsh_nxt   = ACC_W'(dvs_c) << (QUO_W - 1);
        quo_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        // Restoring division, one quotient bit per cycle
        if (rem_r >= dsh_r) begin
          rem_nxt = rem_r - dsh_r;
          quo_nxt = {quo_r[QUO_W-2:0], 1'b1};
        end else begin
          quo_nxt = {quo_r[QUO_W-2:0], 1'b0};
        end
        dsh_nxt = dsh_r >> 1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 6'(QUO_W - 1)) begin
          state_nxt = ST_RND;
        end
      end
      ST_RND: begin
        // Round half away from zero, then offset by the edge start
        res_nxt[axis_r] = rval[COORD_W-1:0];
        k_nxt           = '0;
        if (axis_r == 2'd2) begin
          out_vld_nxt = 1'b1;
          state_nxt   = ST_IDLE;
        end else begin
          axis_nxt  = axis_r + 1'b1;
          state_nxt = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      ph_r      <= PH_SETUP;
      k_r       <= '0;
      axis_r    <= '0;
      cnt_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      ph_r      <= ph_nxt;
      k_r       <= k_nxt;
      axis_r    <= axis_nxt;
      cnt_r     <= cnt_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r    <= cur_nxt;
    ma_r     <= ma_nxt;
    mb_r     <= mb_nxt;
    psign_r  <= psign_nxt;
    prod_r   <= prod_nxt;
    acc_r    <= acc_nxt;
    d00_r    <= d00_nxt;
    d01_r    <= d01_nxt;
    d11_r    <= d11_nxt;
    d20_r    <= d20_nxt;
    d21_r    <= d21_nxt;
    tn_r     <= tn_nxt;
    ee_r     <= ee_nxt;
    den_r    <= den_nxt;
    vn_r     <= vn_nxt;
    wn_r     <= wn_nxt;
    un_r     <= un_nxt;
    rem_r    <= rem_nxt;
    dsh_r    <= dsh_nxt;
    dvs_r    <= dvs_nxt;
    quo_r    <= quo_nxt;
    nneg_r   <= nneg_nxt;
    res_r    <= res_nxt;
    region_r <= region_nxt;
    degen_r  <= degen_nxt;
  end

endmodule

>>> hw/rtl/closest_point_on_triangle.sv
// Products run on the shared 140x8 multiplier; quotients on the shared restoring divider.
// Throughput: one word per back-end run; a 4-word queue plus front stage buffer input.
// busy rises only when the queue and the front stage are both full.
// Reset: rst_n synchronous, active low; empties the queue and idles the sequencer.
// Results show for one cycle on out_valid; the receiver cannot stall.
module closest_point_on_triangle (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_vert_a_x,
  input  logic signed [31:0] in_vert_a_y,
  input  logic signed [31:0] in_vert_a_z,
  input  logic signed [31:0] in_vert_b_x,
  input  logic signed [31:0] in_vert_b_y,
  input  logic signed [31:0] in_vert_b_z,
  input  logic signed [31:0] in_vert_c_x,
  input  logic signed [31:0] in_vert_c_y,
  input  logic signed [31:0] in_vert_c_z,
  input  logic signed [31:0] in_query_x,
  input  logic signed [31:0] in_query_y,
  input  logic signed [31:0] in_query_z,
  output logic               out_valid,
  output logic signed [31:0] out_near_x,
  output logic signed [31:0] out_near_y,
  output logic signed [31:0] out_near_z,
  output logic [1:0]         out_region,
  output logic               out_degenerate
);
  import cpt_pkg::*;

  tri_pt_t in_pt;
  item_t   f_item, q_rd_item;
  logic    q_push, q_full, q_pop, q_vld;
  coord3_t near;
  region_t region;

  // Pack the input word
  always_comb begin
    in_pt.a[0] = in_vert_a_x;
    in_pt.a[1] = in_vert_a_y;
    in_pt.a[2] = in_vert_a_z;
    in_pt.b[0] = in_vert_b_x;
    in_pt.b[1] = in_vert_b_y;
    in_pt.b[2] = in_vert_b_z;
    in_pt.c[0] = in_vert_c_x;
    in_pt.c[1] = in_vert_c_y;
    in_pt.c[2] = in_vert_c_z;
    in_pt.q[0] = in_query_x;
    in_pt.q[1] = in_query_y;
    in_pt.q[2] = in_query_z;
  end

  cpt_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .in_pt  (in_pt),
    .q_full (q_full),
    .q_push (q_push),
    .q_item (f_item)
  );

  cpt_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_item (f_item),
    .full    (q_full),
    .pop     (q_pop),
    .vld     (q_vld),
    .rd_item (q_rd_item)
  );

  cpt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_vld      (q_vld),
    .q_item     (q_rd_item),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .near       (near),
    .region     (region),
    .degenerate (out_degenerate)
  );

  assign out_near_x = $signed(near[0]);
  assign out_near_y = $signed(near[1]);
  assign out_near_z = $signed(near[2]);
  assign out_region = region;

endmodule

>>> tb/closest_point_checker.sv
`timescale 1ns / 1ps
// Checker for closest_point_on_triangle: predicts each result word and compares it.
module closest_point_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [31:0] in_vert_a_x,
  input  logic [31:0] in_vert_a_y,
  input  logic [31:0] in_vert_a_z,
  input  logic [31:0] in_vert_b_x,
  input  logic [31:0] in_vert_b_y,
  input  logic [31:0] in_vert_b_z,
  input  logic [31:0] in_vert_c_x,
  input  logic [31:0] in_vert_c_y,
  input  logic [31:0] in_vert_c_z,
  input  logic [31:0] in_query_x,
  input  logic [31:0] in_query_y,
  input  logic [31:0] in_query_z,
  input  logic        out_valid,
  input  logic [31:0] out_near_x,
  input  logic [31:0] out_near_y,
  input  logic [31:0] out_near_z,
  input  logic [1:0]  out_region,
  input  logic        out_degenerate,
  output int          pending,
  output int          errors
);
  import cpt_pkg::*;

  // 192-bit exact arithmetic, wrapping at 192 bits
  typedef logic signed [191:0] wide_t;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    region_t     region;
    logic        degen;
  } near_word_t;

  near_word_t near_q[$];

  function automatic wide_t dot3(input wide_t p [3], input wide_t r [3]);
    return p[0] * r[0] + p[1] * r[1] + p[2] * r[2];
  endfunction

  // n / d rounded to nearest, ties away from zero; d > 0
  function automatic logic [63:0] round_div(input wide_t n, input wide_t d);
    logic [191:0] mag_n;
    logic [191:0] quo;
    logic [191:0] rem;
    logic [63:0]  mag;
    mag_n = n[191] ? -n : n;
    quo = mag_n / $unsigned(d);
    rem = mag_n % $unsigned(d);
    if (rem >= $unsigned(d) - rem) quo = quo + 1;
    mag = {1'b0, quo[62:0]};
    return n[191] ? -mag : mag;
  endfunction

  // Clamped projection of q onto segment s->t
  function automatic void seg_near(input wide_t s [3], input wide_t t [3],
                                   input wide_t q [3], output logic [31:0] r [3]);
    wide_t e[3];
    wide_t sq[3];
    wide_t tn;
    wide_t ee;
    logic [63:0] step;
    for (int i = 0; i < 3; i++) begin
      e[i]  = t[i] - s[i];
      sq[i] = q[i] - s[i];
    end
    tn = dot3(sq, e);
    ee = dot3(e, e);
    for (int i = 0; i < 3; i++) begin
      if (tn <= 0) begin
        r[i] = s[i][31:0];
      end else if (ee == 0 || tn - ee >= 0) begin
        r[i] = t[i][31:0];
      end else begin
        step = round_div(e[i] * tn, ee);
        r[i] = s[i][31:0] + step[31:0];
      end
    end
  endfunction

  function automatic near_word_t predict_near(input logic [31:0] pts [12]);
    wide_t a[3], b[3], c[3], q[3], ab[3], ac[3], aq[3];
    wide_t d00, d01, d11, d20, d21, den, vn, wn, un, num;
    logic [31:0] r[3];
    logic [63:0] rd;
    near_word_t w;
    for (int i = 0; i < 3; i++) begin
      a[i] = $signed(pts[i]);
      b[i] = $signed(pts[3 + i]);
      c[i] = $signed(pts[6 + i]);
      q[i] = $signed(pts[9 + i]);
      ab[i] = b[i] - a[i];
      ac[i] = c[i] - a[i];
      aq[i] = q[i] - a[i];
    end
    d00 = dot3(ab, ab);
    d01 = dot3(ab, ac);
    d11 = dot3(ac, ac);
    d20 = dot3(aq, ab);
    d21 = dot3(aq, ac);
    den = d00 * d11 - d01 * d01;
    w.region = REG_INSIDE;
    w.degen  = 1'b0;
    if (den <= 0) begin
      // zero-area triangle: hand back the query point
      for (int i = 0; i < 3; i++) r[i] = q[i][31:0];
      w.degen = 1'b1;
    end else begin
      vn = d11 * d20 - d01 * d21;
      wn = d00 * d21 - d01 * d20;
      un = den - vn - wn;
      if (un >= 0 && vn >= 0 && wn >= 0) begin
        for (int i = 0; i < 3; i++) begin
          num = un * a[i] + vn * b[i] + wn * c[i];
          rd = round_div(num, den);
          r[i] = rd[31:0];
        end
      end else if (vn < 0) begin
        w.region = REG_AC;
        seg_near(a, c, q, r);
      end else if (wn < 0) begin
        w.region = REG_AB;
        seg_near(a, b, q, r);
      end else begin
        w.region = REG_BC;
        seg_near(b, c, q, r);
      end
    end
    w.x = r[0];
    w.y = r[1];
    w.z = r[2];
    return w;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  // Push on accepted input words, pop and compare on result strobes
  always @(posedge clk) begin
    logic [31:0] pts [12];
    near_word_t want;
    if (!rst_n) begin
      errors = 0;
      near_q.delete();
    end else begin
      if (start && !busy) begin
        pts = '{in_vert_a_x, in_vert_a_y, in_vert_a_z, in_vert_b_x, in_vert_b_y,
                in_vert_b_z, in_vert_c_x, in_vert_c_y, in_vert_c_z,
                in_query_x, in_query_y, in_query_z};
        near_q.push_back(predict_near(pts));
      end
      if (out_valid) begin
        if (near_q.size() == 0) begin
          $display("%0t: result word with nothing expected: %h %h %h r%0d d%0b", $time,
                   out_near_x, out_near_y, out_near_z, out_region, out_degenerate);
          errors++;
        end else begin
          want = near_q.pop_front();
          check_field("near_x", want.x, out_near_x);
          check_field("near_y", want.y, out_near_y);
          check_field("near_z", want.z, out_near_z);
          check_field("region", 32'(want.region), 32'(out_region));
          check_field("degenerate", 32'(want.degen), 32'(out_degenerate));
        end
      end
    end
    pending = near_q.size();
  end

endmodule

>>> tb/tb_closest_point_on_triangle.sv
`timescale 1ns / 1ps
// Testbench top for closest_point_on_triangle: stimulus, clock, reset and verdict.
module tb_closest_point_on_triangle;
  import cpt_pkg::*;

  localparam int  N_RANDOM = 1630;
  localparam int  ONE      = 65536;
  localparam longint CYCLE_LIMIT = 6000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [31:0] pts [12] = '{default: '0};
  logic        out_valid;
  logic [31:0] out_near_x, out_near_y, out_near_z;
  logic [1:0]  out_region;
  logic        out_degenerate;
  int          pending;
  int          errors;
  longint      cycles = 0;
  int          burst_left = 4;

  closest_point_on_triangle dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_vert_a_x(pts[0]), .in_vert_a_y(pts[1]), .in_vert_a_z(pts[2]),
    .in_vert_b_x(pts[3]), .in_vert_b_y(pts[4]), .in_vert_b_z(pts[5]),
    .in_vert_c_x(pts[6]), .in_vert_c_y(pts[7]), .in_vert_c_z(pts[8]),
    .in_query_x(pts[9]), .in_query_y(pts[10]), .in_query_z(pts[11]),
    .out_valid(out_valid), .out_near_x(out_near_x), .out_near_y(out_near_y),
    .out_near_z(out_near_z), .out_region(out_region), .out_degenerate(out_degenerate)
  );

  closest_point_checker chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_vert_a_x(pts[0]), .in_vert_a_y(pts[1]), .in_vert_a_z(pts[2]),
    .in_vert_b_x(pts[3]), .in_vert_b_y(pts[4]), .in_vert_b_z(pts[5]),
    .in_vert_c_x(pts[6]), .in_vert_c_y(pts[7]), .in_vert_c_z(pts[8]),
    .in_query_x(pts[9]), .in_query_y(pts[10]), .in_query_z(pts[11]),
    .out_valid(out_valid), .out_near_x(out_near_x), .out_near_y(out_near_y),
    .out_near_z(out_near_z), .out_region(out_region), .out_degenerate(out_degenerate),
    .pending(pending), .errors(errors)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Drive one word, hold until accepted, then maybe open a gap between bursts
  task automatic send_word(input logic [31:0] ax, ay, az, bx, by, bz,
                           input logic [31:0] cx, cy, cz, qx, qy, qz);
    int gap;
    pts[0] <= ax; pts[1] <= ay; pts[2]  <= az;
    pts[3] <= bx; pts[4] <= by; pts[5]  <= bz;
    pts[6] <= cx; pts[7] <= cy; pts[8]  <= cz;
    pts[9] <= qx; pts[10] <= qy; pts[11] <= qz;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 900) : $urandom_range(0, 12);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
  endtask

  function automatic logic [31:0] small_coord();
    return $urandom_range(0, 1 << 19) - (1 << 18);
  endfunction

  initial begin
    logic [31:0] v [12];
    logic [31:0] dx, dy, dz;
    int kind, k1, k2;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: degenerate, each region, clamped ends, extremes
    send_word(0, 0, 0, 0, 0, 0, 0, 0, 0, ONE, -ONE, 7);
    send_word(0, 0, 0, ONE, ONE, ONE, 2*ONE, 2*ONE, 2*ONE, 5, 6, 7);
    send_word(0, 0, 0, 3*ONE, 0, 0, 0, 3*ONE, 0, ONE, ONE, 4*ONE);
    send_word(0, 0, 0, 2*ONE, 0, 0, 0, 2*ONE, 0, -ONE, ONE, ONE);
    send_word(0, 0, 0, 2*ONE, 0, 0, 0, 2*ONE, 0, ONE, -ONE, -ONE);
    send_word(0, 0, 0, 2*ONE, 0, 0, 0, 2*ONE, 0, 2*ONE, 2*ONE, 0);
    send_word(0, 0, 0, 2*ONE, 0, 0, 0, 2*ONE, 0, -ONE, -ONE, 0);
    send_word(0, 0, 0, 2*ONE, 0, 0, 0, 2*ONE, 0, -ONE, 5*ONE, 0);
    send_word(0, 0, 0, 2*ONE, 0, 0, 0, 2*ONE, 0, 5*ONE, -ONE, 3);
    send_word(0, 0, 0, 2*ONE, 0, 0, 0, 2*ONE, 0, 5*ONE, 0, 0);
    send_word(0, 0, 0, 3, 0, 0, 0, 2, 0, 1, 1, 0);
    send_word(0, 0, 0, 3, 0, 0, 0, 3, 0, 1, 1, 9);
    send_word(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
              32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
              32'h80000000, 32'h80000000, 32'h80000000);
    send_word(32'h80000000, 0, 0, 32'h7fffffff, 0, 0, 0, 32'h7fffffff, 0,
              32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    send_word(32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h80000000,
              32'h80000000, 32'h80000000, 32'h7fffffff, 32'h80000000,
              32'hffffffff, 32'hffffffff, 32'h7fffffff);
    send_word(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
              32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 0, 0, 0);

    // Random: mostly well-shaped triangles, some full-range, some flat
    for (int n = 0; n < N_RANDOM; n++) begin
      kind = $urandom_range(0, 9);
      for (int i = 0; i < 12; i++) v[i] = (kind < 3) ? $urandom() : small_coord();
      if (kind == 8) begin
        // collinear vertices
        dx = $urandom_range(0, 4096) - 2048;
        dy = $urandom_range(0, 4096) - 2048;
        dz = $urandom_range(0, 4096) - 2048;
        k1 = $urandom_range(0, 40) - 20;
        k2 = $urandom_range(0, 40) - 20;
        v[3] = v[0] + k1 * dx; v[4] = v[1] + k1 * dy; v[5] = v[2] + k1 * dz;
        v[6] = v[0] + k2 * dx; v[7] = v[1] + k2 * dy; v[8] = v[2] + k2 * dz;
      end else if (kind == 9) begin
        // query sits on or next to a vertex
        k1 = 3 * $urandom_range(0, 2);
        for (int i = 0; i < 3; i++) v[9 + i] = v[k1 + i] + $urandom_range(0, 2) - 1;
      end
      send_word(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8], v[9], v[10], v[11]);
    end
    start <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
